[hw/rtl/cst_pkg.sv]
package cst_pkg;

  // fixed field widths
  localparam int unsigned ModeW   = 2;
  localparam int unsigned SemIdW  = 4;
  localparam int unsigned ProcIdW = 4;
  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 2;

  // only entries reachable through a 4-bit index are usable
  localparam int unsigned MaxEntries = 16;

  localparam int unsigned NUM_SEMAPHORES = 16;
  localparam int unsigned NUM_PROCESSES  = 16;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_SIGNAL = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_ALLOC = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_WAKE   = 2'd2
  } state_e;

endpackage

[hw/rtl/cst_if.sv]
interface cst_req_if import cst_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [ModeW-1:0]            mode;
  logic [SemIdW-1:0]           sem_id;
  logic [ProcIdW-1:0]          proc_id;
  logic signed [CountW-1:0]    init_value;

  modport source (output valid, mode, sem_id, proc_id, init_value, input ready);
  modport sink   (input valid, mode, sem_id, proc_id, init_value, output ready);
endinterface

interface cst_rsp_if import cst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [SemIdW-1:0]   alloc_index;
  logic                caller_blocks;
  logic                wake_valid;
  logic [ProcIdW-1:0]  wake_proc;

  modport source (output valid, status, alloc_index, caller_blocks, wake_valid, wake_proc,
                  input ready);
  modport sink   (input valid, status, alloc_index, caller_blocks, wake_valid, wake_proc,
                  output ready);
endinterface

[hw/rtl/cst_ram.sv]
module cst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/counting_semaphore_table.sv]
// Table of counting semaphores, each with a FIFO of waiting process ids. A word on req_i
// allocates the lowest free entry, waits on an entry or signals it; one result word per
// request comes out on rsp_o. Requests are handled one at a time: allocate, wait and a
// signal with an empty queue go through an entry memory read, then write-back; a signal
// that releases a waiter also reads the waiter memory before its result. The result sits in
// an output register, so the next request is taken while it waits to be read. Entry and
// waiter memories need no clearing after reset: per-entry in-use flags gate the entry
// memory, and the waiter memory is only read within a queue's length.
module counting_semaphore_table import cst_pkg::*; #(
  parameter int unsigned NumSemaphores = NUM_SEMAPHORES,
  parameter int unsigned NumProcesses  = NUM_PROCESSES
) (
  input  logic clk_i,
  input  logic rst_ni,
  cst_req_if.sink   req_i,
  cst_rsp_if.source rsp_o
);

  localparam int unsigned NumEntries = (NumSemaphores < MaxEntries) ? NumSemaphores
                                                                    : MaxEntries;
  localparam int unsigned EntryAw    = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int unsigned SlotW      = (NumProcesses > 1) ? $clog2(NumProcesses) : 1;
  localparam int unsigned LenW       = $clog2(NumProcesses + 1);
  localparam int unsigned EntryW     = CountW + 2 * SlotW + LenW;
  localparam int unsigned EntryDepth = 2 ** EntryAw;
  localparam int unsigned WaitDepth  = 2 ** (EntryAw + SlotW);

  state_e state_q, state_d;

  logic [NumEntries-1:0] in_use_q, in_use_d;

  // latched request
  logic [ModeW-1:0]         mode_q;
  logic [SemIdW-1:0]        sid_q;
  logic [ProcIdW-1:0]       pid_q;
  logic signed [CountW-1:0] init_q;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [StatusW-1:0]  status_q;
  logic [SemIdW-1:0]   alloc_q;
  logic                blocks_q;
  logic                wake_q;
  logic [ProcIdW-1:0]  wproc_q;

  logic                load_out;
  logic [StatusW-1:0]  res_status;
  logic [SemIdW-1:0]   res_alloc;
  logic                res_blocks;
  logic                res_wake;
  logic [ProcIdW-1:0]  res_wproc;

  // memory ports
  logic                ent_re, ent_we;
  logic [EntryAw-1:0]  ent_raddr, ent_waddr;
  logic [EntryW-1:0]   ent_wdata, ent_rdata;
  logic                wait_re, wait_we;
  logic [EntryAw+SlotW-1:0] wait_raddr, wait_waddr;
  logic [ProcIdW-1:0]  wait_rdata;

  logic                     accept;
  logic                     can_out;
  logic [EntryAw-1:0]       sid_idx;
  logic                     sid_ok;
  logic signed [CountW-1:0] ent_cnt;
  logic [SlotW-1:0]         ent_head, ent_tail;
  logic [LenW-1:0]          ent_len;
  logic signed [CountW-1:0] cnt_dec, cnt_inc;
  logic [SlotW-1:0]         head_nxt, tail_nxt;
  logic                     wait_store;
  logic                     free_found;
  logic [EntryAw-1:0]       free_idx;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign can_out     = !out_valid_q || rsp_o.ready;

  assign sid_idx = sid_q[EntryAw-1:0];
  assign sid_ok  = ({1'b0, sid_q} < (SemIdW+1)'(NumEntries)) && in_use_q[sid_idx];

  assign ent_cnt  = $signed(ent_rdata[EntryW-1 -: CountW]);
  assign ent_head = ent_rdata[SlotW+SlotW+LenW-1 -: SlotW];
  assign ent_tail = ent_rdata[SlotW+LenW-1 -: SlotW];
  assign ent_len  = ent_rdata[LenW-1:0];

  // saturating count updates
  assign cnt_dec = (ent_cnt == {1'b1, {(CountW-1){1'b0}}}) ? ent_cnt : ent_cnt - CountW'(1);
  assign cnt_inc = (ent_cnt == {1'b0, {(CountW-1){1'b1}}}) ? ent_cnt : ent_cnt + CountW'(1);

  // circular slot pointers
  assign head_nxt = (ent_head == SlotW'(NumProcesses - 1)) ? '0 : ent_head + SlotW'(1);
  assign tail_nxt = (ent_tail == SlotW'(NumProcesses - 1)) ? '0 : ent_tail + SlotW'(1);

  assign wait_store = cnt_dec[CountW-1] && (ent_len < LenW'(NumProcesses));

  // lowest free entry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = EntryAw'(i);
      end
    end
  end

  assign ent_raddr  = req_i.sem_id[EntryAw-1:0];
  assign wait_raddr = {sid_idx, ent_head};
  assign wait_waddr = {sid_idx, ent_tail};

  always_comb begin
    state_d    = state_q;
    in_use_d   = in_use_q;
    ent_re     = 1'b0;
    ent_we     = 1'b0;
    ent_waddr  = sid_idx;
    ent_wdata  = {ent_cnt, ent_head, ent_tail, ent_len};
    wait_re    = 1'b0;
    wait_we    = 1'b0;
    load_out   = 1'b0;
    res_status = STATUS_OK;
    res_alloc  = '0;
    res_blocks = 1'b0;
    res_wake   = 1'b0;
    res_wproc  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ent_re  = 1'b1;
          state_d = ST_LOOKUP;
        end
      end

      ST_LOOKUP: begin
        unique case (mode_q)
          MODE_ALLOC: begin
            if (can_out) begin
              load_out = 1'b1;
              state_d  = ST_IDLE;
              if (free_found) begin
                ent_we             = 1'b1;
                ent_waddr          = free_idx;
                ent_wdata          = {init_q, {(2*SlotW+LenW){1'b0}}};
                in_use_d[free_idx] = 1'b1;
                res_alloc          = SemIdW'(free_idx);
              end else begin
                res_status = STATUS_FULL;
              end
            end
          end

          MODE_WAIT: begin
            if (can_out) begin
              load_out = 1'b1;
              state_d  = ST_IDLE;
              if (!sid_ok) begin
                res_status = STATUS_NOT_ALLOC;
              end else begin
                ent_we     = 1'b1;
                res_blocks = cnt_dec[CountW-1];
                wait_we    = wait_store;
                ent_wdata  = {cnt_dec, ent_head,
                              wait_store ? tail_nxt : ent_tail,
                              wait_store ? ent_len + LenW'(1) : ent_len};
              end
            end
          end

          MODE_SIGNAL: begin
            if (!sid_ok) begin
              if (can_out) begin
                load_out   = 1'b1;
                res_status = STATUS_NOT_ALLOC;
                state_d    = ST_IDLE;
              end
            end else if (ent_len != '0) begin
              // release the oldest waiter, its id comes back next cycle
              ent_we    = 1'b1;
              ent_wdata = {cnt_inc, head_nxt, ent_tail, ent_len - LenW'(1)};
              wait_re   = 1'b1;
              state_d   = ST_WAKE;
            end else if (can_out) begin
              ent_we    = 1'b1;
              ent_wdata = {cnt_inc, ent_head, ent_tail, ent_len};
              load_out  = 1'b1;
              state_d   = ST_IDLE;
            end
          end

          default: begin
            if (can_out) begin
              load_out = 1'b1;
              state_d  = ST_IDLE;
            end
          end
        endcase
      end

      ST_WAKE: begin
        if (can_out) begin
          load_out  = 1'b1;
          res_wake  = 1'b1;
          res_wproc = wait_rdata;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_use_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= req_i.mode;
      sid_q  <= req_i.sem_id;
      pid_q  <= req_i.proc_id;
      init_q <= req_i.init_value;
    end
    if (load_out) begin
      status_q <= res_status;
      alloc_q  <= res_alloc;
      blocks_q <= res_blocks;
      wake_q   <= res_wake;
      wproc_q  <= res_wproc;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.alloc_index   = alloc_q;
  assign rsp_o.caller_blocks = blocks_q;
  assign rsp_o.wake_valid    = wake_q;
  assign rsp_o.wake_proc     = wproc_q;

  // count, head, tail and length per entry
  cst_ram #(
    .Width (EntryW),
    .Depth (EntryDepth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // waiting process ids, one row of slots per entry
  cst_ram #(
    .Width (ProcIdW),
    .Depth (WaitDepth)
  ) u_waiter_ram (
    .clk_i   (clk_i),
    .we_i    (wait_we),
    .waddr_i (wait_waddr),
    .wdata_i (pid_q),
    .re_i    (wait_re),
    .raddr_i (wait_raddr),
    .rdata_o (wait_rdata)
  );

  // allocated entries are never freed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((in_use_q & $past(in_use_q)) == $past(in_use_q)))
    else $error("in-use flag cleared");

  // a rejected request reports nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != STATUS_OK) |->
      (alloc_q == '0 && !blocks_q && !wake_q && wproc_q == '0))
    else $error("error result carries payload");

  // a release only follows a lookup of a signal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAKE && $past(state_q) != ST_WAKE) |->
      ($past(state_q) == ST_LOOKUP && mode_q == MODE_SIGNAL))
    else $error("wake without signal lookup");

  // a result never both blocks and wakes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(blocks_q && wake_q))
    else $error("result blocks and wakes");

endmodule

[tb/tb_counting_semaphore_table.sv]
module tb_counting_semaphore_table;
  import cst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam int unsigned RandomOps = 1600;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic [SemIdW-1:0]        sem_id;
    logic [ProcIdW-1:0]       proc_id;
    logic signed [CountW-1:0] init_value;
  } sem_op_t;

  typedef struct packed {
    status_e              status;
    logic [SemIdW-1:0]    alloc_index;
    logic                 caller_blocks;
    logic                 wake_valid;
    logic [ProcIdW-1:0]   wake_proc;
  } sem_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic    req_valid = 1'b0;
  sem_op_t req_word = '0;
  logic    rsp_ready = 1'b0;

  cst_req_if req_if ();
  cst_rsp_if rsp_if ();

  assign req_if.valid      = req_valid;
  assign req_if.mode       = req_word.mode;
  assign req_if.sem_id     = req_word.sem_id;
  assign req_if.proc_id    = req_word.proc_id;
  assign req_if.init_value = req_word.init_value;
  assign rsp_if.ready      = rsp_ready;

  counting_semaphore_table uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // shadow copy of the semaphore table
  bit          sem_used [MaxEntries];
  shortint     sem_count [MaxEntries];
  logic [ProcIdW-1:0] sem_waiters [MaxEntries][$];

  sem_op_t     pending_ops [$];
  sem_result_t expected_results [$];
  sem_result_t want;

  int unsigned total_ops;
  int unsigned ops_accepted;
  int unsigned results_seen;
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  int unsigned blocked_waits;
  int unsigned dropped_waiters;
  int unsigned wakeups;
  int unsigned full_allocs;
  int unsigned rejected_ops;

  function automatic void add_op(logic [ModeW-1:0] m, logic [SemIdW-1:0] s,
                                 logic [ProcIdW-1:0] p, logic [CountW-1:0] v);
    sem_op_t op;
    op.mode = m;
    op.sem_id = s;
    op.proc_id = p;
    op.init_value = v;
    pending_ops.push_back(op);
  endfunction

  function automatic sem_result_t apply_sem_op(sem_op_t op);
    sem_result_t res;
    int c;
    bit found;
    int idx;
    res = '0;
    found = 1'b0;
    idx = 0;
    if (op.mode == MODE_ALLOC) begin
      for (int i = 0; i < NUM_SEMAPHORES && i < MaxEntries; i++) begin
        if (!found && !sem_used[i]) begin
          found = 1'b1;
          idx = i;
        end
      end
      if (found) begin
        sem_used[idx] = 1'b1;
        sem_count[idx] = op.init_value;
        sem_waiters[idx].delete();
        res.alloc_index = idx[SemIdW-1:0];
      end else begin
        res.status = STATUS_FULL;
        full_allocs++;
      end
    end else if (op.mode == MODE_WAIT || op.mode == MODE_SIGNAL) begin
      if (int'(op.sem_id) >= NUM_SEMAPHORES || !sem_used[op.sem_id]) begin
        res.status = STATUS_NOT_ALLOC;
        rejected_ops++;
      end else if (op.mode == MODE_WAIT) begin
        c = int'(sem_count[op.sem_id]);
        if (c > -32768) c--;
        sem_count[op.sem_id] = shortint'(c);
        if (c < 0) begin
          res.caller_blocks = 1'b1;
          blocked_waits++;
          // a full wait queue still blocks the caller but loses its id
          if (sem_waiters[op.sem_id].size() < NUM_PROCESSES)
            sem_waiters[op.sem_id].push_back(op.proc_id);
          else
            dropped_waiters++;
        end
      end else begin
        c = int'(sem_count[op.sem_id]);
        if (c < 32767) c++;
        sem_count[op.sem_id] = shortint'(c);
        if (sem_waiters[op.sem_id].size() != 0) begin
          res.wake_valid = 1'b1;
          res.wake_proc = sem_waiters[op.sem_id].pop_front();
          wakeups++;
        end
      end
    end
    return res;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_if.ready) begin
        expected_results.push_back(apply_sem_op(req_word));
        ops_accepted++;
      end
      send_idle_pct = (ops_accepted < total_ops / 3) ? 31 :
                      (ops_accepted < 2 * total_ops / 3) ? 56 : 0;
      if (!req_valid || req_if.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req_word <= pending_ops.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing outstanding: status %0d", rsp_if.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            errors++;
          end
          if (rsp_if.alloc_index !== want.alloc_index) begin
            $error("alloc_index: expected %0d, got %0d", want.alloc_index, rsp_if.alloc_index);
            errors++;
          end
          if (rsp_if.caller_blocks !== want.caller_blocks) begin
            $error("caller_blocks: expected %0d, got %0d", want.caller_blocks,
                   rsp_if.caller_blocks);
            errors++;
          end
          if (rsp_if.wake_valid !== want.wake_valid) begin
            $error("wake_valid: expected %0d, got %0d", want.wake_valid, rsp_if.wake_valid);
            errors++;
          end
          if (rsp_if.wake_proc !== want.wake_proc) begin
            $error("wake_proc: expected %0d, got %0d", want.wake_proc, rsp_if.wake_proc);
            errors++;
          end
        end
      end
      recv_idle_pct = (ops_accepted < total_ops / 3) ? 56 :
                      (ops_accepted < 2 * total_ops / 3) ? 31 : 0;
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n && !(req_valid && req_if.ready) && !(rsp_if.valid && rsp_ready)) begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  initial begin
    int unsigned random_ops;
    int unsigned pick;
    int unsigned burst_len;
    logic [SemIdW-1:0] target;
    logic [ModeW-1:0] op_mode;
    logic signed [CountW-1:0] start_count;

    // rejects before anything is allocated, then the unused mode
    add_op(MODE_WAIT, 4'd0, 4'd5, 16'h0000);
    add_op(MODE_SIGNAL, 4'd15, 4'd0, 16'h0000);
    add_op(ModeUnused, 4'd15, 4'd15, 16'hFFFF);
    // entries 0..2 at zero and both count limits
    add_op(MODE_ALLOC, 4'd0, 4'd0, 16'h0000);
    add_op(MODE_ALLOC, 4'd9, 4'd3, 16'h7FFF);
    add_op(MODE_ALLOC, 4'd15, 4'd15, 16'h8000);
    add_op(MODE_SIGNAL, 4'd1, 4'd0, 16'h0000);
    add_op(MODE_WAIT, 4'd2, 4'd15, 16'hFFFF);
    // fifo order on entry 0
    add_op(MODE_WAIT, 4'd0, 4'd10, 16'h0000);
    add_op(MODE_WAIT, 4'd0, 4'd5, 16'h0000);
    add_op(MODE_SIGNAL, 4'd0, 4'd0, 16'h0000);
    add_op(MODE_SIGNAL, 4'd0, 4'd0, 16'h0000);
    add_op(MODE_SIGNAL, 4'd0, 4'd0, 16'h0000);
    add_op(MODE_WAIT, 4'd0, 4'd3, 16'h0000);
    add_op(MODE_ALLOC, 4'd0, 4'd0, 16'h0001);
    add_op(MODE_WAIT, 4'd3, 4'd6, 16'h5555);
    add_op(MODE_SIGNAL, 4'd2, 4'd0, 16'hAAAA);
    add_op(MODE_WAIT, 4'd4, 4'd1, 16'h0000);
    add_op(MODE_ALLOC, 4'd0, 4'd0, 16'hFFFF);
    add_op(MODE_WAIT, 4'd4, 4'd15, 16'h7FFF);

    // random part: mostly bursts of waits or signals on one entry
    random_ops = 0;
    while (random_ops < RandomOps) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        op_mode = ModeW'($urandom_range(0, 3));
        add_op(op_mode, SemIdW'($urandom_range(0, 15)), ProcIdW'($urandom_range(0, 15)),
               CountW'($urandom_range(0, 65535)));
        if (op_mode != ModeUnused) random_ops++;
      end else if (pick < 14) begin
        case ($urandom_range(0, 7))
          0: start_count = 16'h7FFF;
          1: start_count = 16'h8000;
          2, 3: start_count = CountW'($urandom_range(0, 65535));
          default: start_count = CountW'(int'($urandom_range(0, 7)) - 3);
        endcase
        add_op(MODE_ALLOC, SemIdW'($urandom_range(0, 15)), ProcIdW'($urandom_range(0, 15)),
               start_count);
        random_ops++;
      end else begin
        op_mode = $urandom_range(0, 1) ? MODE_WAIT : MODE_SIGNAL;
        target = SemIdW'($urandom_range(0, 15));
        burst_len = $urandom_range(1, 24);
        repeat (burst_len) begin
          add_op(op_mode, target, ProcIdW'($urandom_range(0, 15)),
                 CountW'($urandom_range(0, 65535)));
          random_ops++;
        end
      end
    end
    total_ops = pending_ops.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_accepted < total_ops) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d requests, %0d results: %0d blocking waits (%0d past a full queue),",
             ops_accepted, results_seen, blocked_waits, dropped_waiters);
    $display("  %0d wakeups, %0d allocations on a full table, %0d requests on unallocated entries",
             wakeups, full_allocs, rejected_ops);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/cst_pkg.sv
hw/rtl/cst_if.sv
hw/rtl/cst_ram.sv
hw/rtl/counting_semaphore_table.sv
tb/tb_counting_semaphore_table.sv
